/* sv/srdp_pkg.sv */
package srdp_pkg;

  // Depth of the vector memory, in elements.
  localparam int VEC_DEPTH = 4096;
  localparam int ADDR_W    = $clog2(VEC_DEPTH);

  // Widths of the word fields.
  localparam int COL_W   = 12;
  localparam int VALUE_W = 32;
  localparam int SUM_W   = 64;

  // A column widened to hold both a full column and a full memory address.
  localparam int COL_EXT_W = (ADDR_W > COL_W) ? ADDR_W : COL_W;
  // One bit more, so that the depth itself fits for the range compare.
  localparam int CMP_W = COL_EXT_W + 1;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_MAC   = 2'd1,
    REQ_END   = 2'd2
  } req_t;

endpackage

/* sv/srdp_ram.sv */
module srdp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

/* sv/sparse_row_dot_product.sv */
// Sparse row dot product: a word is either a vector write, which stores a signed Q16.16
// element at a zero-based column, a nonzero, which multiplies its Q16.16 matrix value by
// the stored element and adds the exact Q32.32 product to a saturating 64-bit row sum, or
// a row end, which delivers the row sum with its sticky overflow flag and clears both.
// The block takes one word per clock cycle while req_ready is high. A row-end result
// is offered on the result channel once the row-end word has passed the pipeline in order:
// the registered read of the vector memory completes at the accepting edge, the 32 by 32
// product is registered in stage two, and then the accumulator and the result register
// load. req_ready drops only when a row-end word has reached the accumulator stage while
// the previous result still waits to be taken.
// A vector element must be written before any nonzero reads it; the memory is not
// cleared after reset. Columns at or beyond the memory depth are ignored by writes and
// read as zero by nonzeros. The unused request code is dropped.
module sparse_row_dot_product (
  input  logic                                     clk,
  input  logic                                     rst,

  input  logic                                     req_valid,
  output logic                                     req_ready,
  input  logic [1:0]                               req_type,
  input  logic [srdp_pkg::COL_W-1:0]               column,
  input  logic signed [srdp_pkg::VALUE_W-1:0]      value,

  output logic                                     res_valid,
  input  logic                                     res_ready,
  output logic signed [srdp_pkg::SUM_W-1:0]        row_sum,
  output logic                                     overflow
);

  // The whole pipeline moves together. It holds only when a row end sits in the
  // accumulator stage and the result register is still occupied.
  logic advance;
  logic req_acc;

  // Column decode for the vector memory.
  logic [srdp_pkg::COL_EXT_W-1:0] col_ext;
  logic [srdp_pkg::ADDR_W-1:0]    ram_addr;
  logic                           col_in_range;
  logic                           ram_we;
  logic [srdp_pkg::VALUE_W-1:0]   ram_rdata;

  // Stage one: the memory read is in flight.
  logic                                s1_valid;
  logic                                s1_end;
  logic                                s1_in_range;
  logic signed [srdp_pkg::VALUE_W-1:0] s1_value;

  // Stage two: the product is registered.
  logic                              s2_valid;
  logic                              s2_end;
  logic signed [srdp_pkg::SUM_W-1:0] s2_prod;

  // Row state.
  logic signed [srdp_pkg::SUM_W-1:0] acc;
  logic signed [srdp_pkg::SUM_W-1:0] acc_next;
  logic                              sat_flag;
  logic signed [srdp_pkg::SUM_W-1:0] sum_wrap;
  logic signed [srdp_pkg::SUM_W-1:0] sat_value;
  logic                              add_ovf;

  assign advance   = !(s2_valid && s2_end && res_valid && !res_ready);
  assign req_ready = advance;
  assign req_acc   = req_valid && advance;

  assign col_ext      = srdp_pkg::COL_EXT_W'(column);
  assign ram_addr     = col_ext[srdp_pkg::ADDR_W-1:0];
  assign col_in_range = srdp_pkg::CMP_W'(column) < srdp_pkg::CMP_W'(srdp_pkg::VEC_DEPTH);
  assign ram_we       = req_acc && (req_type == srdp_pkg::REQ_WRITE) && col_in_range;

  srdp_ram #(
    .WIDTH (srdp_pkg::VALUE_W),
    .DEPTH (srdp_pkg::VEC_DEPTH)
  ) u_vec_ram (
    .clk   (clk),
    .en    (advance),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (value),
    .rdata (ram_rdata)
  );

  // Only nonzeros and row ends travel down the pipeline; writes finish at the memory.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= req_acc &&
                  ((req_type == srdp_pkg::REQ_MAC) || (req_type == srdp_pkg::REQ_END));
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_end      <= (req_type == srdp_pkg::REQ_END);
      s1_in_range <= col_in_range;
      s1_value    <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  // An element outside the memory counts as zero.
  always_ff @(posedge clk) begin
    if (advance) begin
      s2_end <= s1_end;
      if (s1_in_range) begin
        s2_prod <= srdp_pkg::SUM_W'(s1_value) * srdp_pkg::SUM_W'($signed(ram_rdata));
      end else begin
        s2_prod <= '0;
      end
    end
  end

  // Signed saturating add: overflow occurs only when both operands share a sign and the
  // wrapped sum does not. The clamp takes the sign of the product.
  always_comb begin
    sum_wrap  = acc + s2_prod;
    add_ovf   = (acc[srdp_pkg::SUM_W-1] == s2_prod[srdp_pkg::SUM_W-1]) &&
                (sum_wrap[srdp_pkg::SUM_W-1] != acc[srdp_pkg::SUM_W-1]);
    sat_value = s2_prod[srdp_pkg::SUM_W-1] ? {1'b1, {(srdp_pkg::SUM_W-1){1'b0}}}
                                           : {1'b0, {(srdp_pkg::SUM_W-1){1'b1}}};
    acc_next  = add_ovf ? sat_value : sum_wrap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      sat_flag <= 1'b0;
    end else if (advance && s2_valid) begin
      if (s2_end) begin
        acc      <= '0;
        sat_flag <= 1'b0;
      end else begin
        acc      <= acc_next;
        sat_flag <= sat_flag || add_ovf;
      end
    end
  end

  // Result register. A row end loads it only when it is empty or being emptied.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && s2_valid && s2_end) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_valid && s2_end) begin
      row_sum  <= acc;
      overflow <= sat_flag;
    end
  end

  // A delivered row end leaves a cleared row behind and a full result register.
  a_row_end_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && s2_valid && s2_end) |=> (acc == '0 && !sat_flag && res_valid))
    else $error("row end did not clear the row state or load the result");

  // A zero product never moves the accumulator.
  a_zero_prod_holds: assert property (@(posedge clk) disable iff (rst)
    (advance && s2_valid && !s2_end && s2_prod == '0) |=> $stable(acc))
    else $error("zero product changed the row sum");

  // A nonzero whose column lies outside the memory contributes nothing.
  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_valid && !s1_in_range) |=> (s2_prod == '0))
    else $error("column outside the memory gave a nonzero product");

endmodule
